// ===== rtl/csp_pkg.sv =====
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types, constants and fixed-point helpers for the cubic spline core.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int KNOT_COUNT = 4;
  localparam int FRAC_BITS  = 16;

  // divider operand width (signed), covers numerators and 3*h divisors
  localparam int DIV_W = 36;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_EVAL  = 2'd2;

  typedef struct packed {
    logic        [1:0]  op;
    logic        [1:0]  knot_index;
    logic signed [31:0] knot_time;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] query_time;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               in_range;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// ===== rtl/csp_mul.sv =====
// ----------------------------------------------------------------------------
// csp_mul
// Shared fixed-point multiplier: (a*b)/2^FRAC truncated toward zero, saturated.
// start runs through the stage1 and done registers while a*b runs through prod and res.
// ----------------------------------------------------------------------------
module csp_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [31:0] res
);

  localparam logic signed [63:0] BIAS = (64'sd1 <<< csp_pkg::FRAC_BITS) - 64'sd1;

  logic signed [63:0] prod;
  logic signed [63:0] biased;
  logic signed [63:0] shifted;
  logic               stage1;

  assign biased  = prod + (prod[63] ? BIAS : 64'sd0);
  assign shifted = biased >>> csp_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      done   <= stage1;
    end
    prod <= 64'(a) * 64'(b);
    res  <= csp_pkg::sat32(shifted);
  end

endmodule

// ===== rtl/csp_div.sv =====
// ----------------------------------------------------------------------------
// csp_div
// Shared radix-2 restoring divider: (n*2^FRAC)/d toward zero, saturated,
// zero for a zero divisor. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module csp_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [csp_pkg::DIV_W-1:0] n,
  input  logic signed [csp_pkg::DIV_W-1:0] d,
  output logic                             done,
  output logic signed [31:0]               res
);

  localparam int DW = csp_pkg::DIV_W;
  localparam int NU = DW + csp_pkg::FRAC_BITS;
  localparam int CW = $clog2(NU + 1);
  localparam logic [NU-1:0] QMAX = NU'(32'h7fffffff);
  localparam logic [NU-1:0] QMIN = NU'(33'h080000000);

  logic          busy;
  logic          fin;
  logic [CW-1:0] cnt;
  logic [NU-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] du;
  logic          neg;
  logic [DW-1:0] absn;
  logic [DW-1:0] absd;
  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW-1:0] rem_nx;

  assign absn   = n[DW-1] ? DW'(-n) : DW'(n);
  assign absd   = d[DW-1] ? DW'(-d) : DW'(d);
  assign rem_sh = {rem, quo[NU-1]};
  assign ge     = rem_sh >= {1'b0, du};
  assign rem_nx = ge ? DW'(rem_sh - {1'b0, du}) : DW'(rem_sh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (d == '0) begin
          res  <= 32'sd0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CW'(NU);
          quo  <= {absn, {csp_pkg::FRAC_BITS{1'b0}}};
          rem  <= '0;
          du   <= absd;
          neg  <= n[DW-1] ^ d[DW-1];
        end
      end else if (busy) begin
        quo <= {quo[NU-2:0], ge};
        rem <= rem_nx;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        if (neg) begin
          res <= (quo > QMIN) ? 32'sh80000000 : 32'(~quo[31:0] + 32'd1);
        end else begin
          res <= (quo > QMAX) ? 32'sh7fffffff : quo[31:0];
        end
      end
    end
  end

endmodule

// ===== rtl/cubic_spline_3d_fit_eval_core.sv =====
// ----------------------------------------------------------------------------
// cubic_spline_3d_fit_eval_core
// Four-knot 3D cubic spline: knot load, coefficient solve and evaluation,
// sequenced over one shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+---------------------------------
//  cmd     | in  | cmd_valid/cmd_stall | csp_pkg::cmd_t (op, knot, query)
//  res     | out | res_valid/res_stall | csp_pkg::res_t (x, y, z, in_range)
//
//  Load writes the knot stores in the cycle it is accepted. Evaluate puts
//  its result item out after up to three segment compares, the dt step,
//  then nine multiplies on the shared multiplier. Solve runs 29 divisions
//  on the one-bit-per-cycle divider. Synchronous reset clears control,
//  widths and coefficients; knots are undefined until loaded. cmd_stall
//  is high while an item is in work; a stalled result holds in the output
//  register while a new item is accepted.
// ----------------------------------------------------------------------------
module cubic_spline_3d_fit_eval_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  csp_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output csp_pkg::res_t res
);

  localparam int DW = csp_pkg::DIV_W;
  localparam logic [31:0] RECIP3 = 32'haaaaaaab;  // ceil(2^33/3)

  typedef enum logic [4:0] {
    ST_IDLE, ST_H, ST_A, ST_W1, ST_M1, ST_W2, ST_M2,
    ST_S, ST_R, ST_R1, ST_R2, ST_C2, ST_C1M, ST_C1, ST_C0M, ST_C0,
    ST_BM, ST_B3, ST_BS, ST_D,
    ST_ESRCH, ST_EDT, ST_EMUL, ST_EOUT
  } state_t;

  // knot stores (no reset, positions indexed knot*3+axis) and fitted coefficients, indexed axis*3+segment
  logic signed [31:0] kt [0:3];
  logic signed [31:0] kp [0:11];
  logic signed [31:0] hw [0:2];
  logic signed [31:0] cb [0:8];
  logic signed [31:0] cc [0:8];
  logic signed [31:0] cd [0:8];

  state_t state;
  logic   pend;
  logic [1:0] ix;
  logic [1:0] ax;
  logic [1:0] k;
  logic [1:0] seg;

  // solve temporaries
  logic signed [31:0] m0, m1, m2, a11, a22, w1, w2;
  logic signed [31:0] r0, r1, r2, tmp;
  logic signed [31:0] s_r [0:2];
  logic signed [31:0] c_r [0:2];
  logic [63:0]        pr;

  // evaluate temporaries
  logic signed [31:0] q_r, dt, v;
  logic signed [31:0] ox [0:2];

  // shared units
  logic                 mul_start, mul_done, div_start, div_done;
  logic signed [31:0]   mul_a, mul_b, mul_res, div_res;
  logic signed [DW-1:0] div_n, div_d;

  logic [1:0]         i_nx;
  logic signed [31:0] c_i, c_nx, sum2, addend;
  logic signed [DW-1:0] diff_p;
  logic [31:0]        absv;
  logic signed [63:0] q3;
  logic               unit_done;

  function automatic logic [3:0] idx3(input logic [1:0] a, input logic [1:0] b);
    return 4'({a, 1'b0}) + 4'(a) + 4'(b);
  endfunction

  csp_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .res(mul_res)
  );

  csp_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .n(div_n), .d(div_d),
    .done(div_done), .res(div_res)
  );

  assign cmd_stall = (state != ST_IDLE);
  assign unit_done = mul_done | div_done;

  assign i_nx   = ix + 2'd1;
  assign c_i    = c_r[ix];
  assign c_nx   = (ix == 2'd2) ? 32'sd0 : c_r[i_nx];
  assign sum2   = csp_pkg::sat32(64'sd2 * 64'(c_i) + 64'(c_nx));
  assign diff_p = DW'(kp[idx3(i_nx, ax)]) - DW'(kp[idx3(ix, ax)]);
  assign absv   = tmp[31] ? (~tmp + 32'd1) : tmp;
  assign q3     = tmp[31] ? -$signed({33'b0, pr[63:33]}) : $signed({33'b0, pr[63:33]});

  always_comb begin
    case (k)
      2'd0:    addend = cc[idx3(ax, seg)];
      2'd1:    addend = cb[idx3(ax, seg)];
      default: addend = kp[idx3(seg, ax)];
    endcase
  end

  // operand routing for the shared units
  always_comb begin
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    div_n = '0;
    div_d = '0;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state)
      ST_M1:   begin mul_a = w1;   mul_b = hw[1];  mul_start = !pend; end
      ST_M2:   begin mul_a = w2;   mul_b = hw[2];  mul_start = !pend; end
      ST_R1:   begin mul_a = w1;   mul_b = r0;     mul_start = !pend; end
      ST_R2:   begin mul_a = w2;   mul_b = r1;     mul_start = !pend; end
      ST_C1M:  begin mul_a = hw[2]; mul_b = c_r[2]; mul_start = !pend; end
      ST_C0M:  begin mul_a = hw[1]; mul_b = c_r[1]; mul_start = !pend; end
      ST_BM:   begin mul_a = sum2; mul_b = hw[ix]; mul_start = !pend; end
      ST_EMUL: begin mul_a = dt;   mul_b = v;      mul_start = !pend; end
      ST_W1:   begin div_n = DW'(hw[1]); div_d = DW'(m0); div_start = !pend; end
      ST_W2:   begin div_n = DW'(hw[2]); div_d = DW'(m1); div_start = !pend; end
      ST_S:    begin div_n = diff_p;     div_d = DW'(hw[ix]); div_start = !pend; end
      ST_C2:   begin div_n = DW'(r2);    div_d = DW'(m2); div_start = !pend; end
      ST_C1:   begin div_n = DW'(tmp);   div_d = DW'(m1); div_start = !pend; end
      ST_C0:   begin div_n = DW'(tmp);   div_d = DW'(m0); div_start = !pend; end
      ST_D: begin
        div_n = DW'(c_nx) - DW'(c_i);
        div_d = DW'(3) * DW'(hw[ix]);
        div_start = !pend;
      end
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend      <= 1'b0;
      res_valid <= 1'b0;
      for (int j = 0; j < 3; j++) begin
        hw[j] <= 32'sd0;
      end
      for (int j = 0; j < 9; j++) begin
        cb[j] <= 32'sd0;
        cc[j] <= 32'sd0;
        cd[j] <= 32'sd0;
      end
    end else begin
      // ST_EOUT owns res_valid in its own cycle
      if (res_valid && !res_stall && state != ST_EOUT) begin
        res_valid <= 1'b0;
      end
      if (mul_start || div_start) begin
        pend <= 1'b1;
      end else if (unit_done) begin
        pend <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              csp_pkg::OP_LOAD: begin
                kt[cmd.knot_index]                  <= cmd.knot_time;
                kp[idx3(cmd.knot_index, 2'd0)]      <= cmd.pos_x;
                kp[idx3(cmd.knot_index, 2'd1)]      <= cmd.pos_y;
                kp[idx3(cmd.knot_index, 2'd2)]      <= cmd.pos_z;
              end
              csp_pkg::OP_SOLVE: begin
                ix    <= 2'd0;
                state <= ST_H;
              end
              csp_pkg::OP_EVAL: begin
                q_r   <= cmd.query_time;
                ix    <= 2'd0;
                state <= ST_ESRCH;
              end
              default: begin end
            endcase
          end
        end

        // segment widths, one per cycle
        ST_H: begin
          hw[ix] <= csp_pkg::sat32(64'(kt[i_nx]) - 64'(kt[ix]));
          if (ix == 2'd2) begin
            state <= ST_A;
          end else begin
            ix <= i_nx;
          end
        end

        ST_A: begin
          m0    <= csp_pkg::sat32(64'sd2 * (64'(hw[0]) + 64'(hw[1])));
          a11   <= csp_pkg::sat32(64'sd2 * (64'(hw[1]) + 64'(hw[2])));
          a22   <= csp_pkg::sat32(64'sd2 * 64'(hw[2]));
          state <= ST_W1;
        end

        ST_W1: if (div_done) begin w1 <= div_res; state <= ST_M1; end
        ST_M1: if (mul_done) begin
          m1    <= csp_pkg::sat32(64'(a11) - 64'(mul_res));
          state <= ST_W2;
        end
        ST_W2: if (div_done) begin w2 <= div_res; state <= ST_M2; end
        ST_M2: if (mul_done) begin
          m2    <= csp_pkg::sat32(64'(a22) - 64'(mul_res));
          ax    <= 2'd0;
          ix    <= 2'd0;
          state <= ST_S;
        end

        // per-axis slopes
        ST_S: if (div_done) begin
          s_r[ix] <= div_res;
          if (ix == 2'd2) begin
            state <= ST_R;
          end else begin
            ix <= i_nx;
          end
        end

        ST_R: begin
          r0    <= csp_pkg::sat32(64'sd3 * (64'(s_r[1]) - 64'(s_r[0])));
          r1    <= csp_pkg::sat32(64'sd3 * (64'(s_r[2]) - 64'(s_r[1])));
          state <= ST_R1;
        end
        ST_R1: if (mul_done) begin
          r1    <= csp_pkg::sat32(64'(r1) - 64'(mul_res));
          state <= ST_R2;
        end
        ST_R2: if (mul_done) begin
          r2    <= csp_pkg::sat32(-64'(mul_res));
          state <= ST_C2;
        end

        // back substitution
        ST_C2: if (div_done) begin c_r[2] <= div_res; state <= ST_C1M; end
        ST_C1M: if (mul_done) begin
          tmp   <= csp_pkg::sat32(64'(r1) - 64'(mul_res));
          state <= ST_C1;
        end
        ST_C1: if (div_done) begin c_r[1] <= div_res; state <= ST_C0M; end
        ST_C0M: if (mul_done) begin
          tmp   <= csp_pkg::sat32(64'(r0) - 64'(mul_res));
          state <= ST_C0;
        end
        ST_C0: if (div_done) begin
          c_r[0] <= div_res;
          ix     <= 2'd0;
          state  <= ST_BM;
        end

        // b = s - (2c_i + c_i+1) h / 3 via reciprocal multiply
        ST_BM: if (mul_done) begin
          tmp              <= mul_res;
          cc[idx3(ax, ix)] <= c_i;
          state            <= ST_B3;
        end
        ST_B3: begin
          pr    <= absv * RECIP3;
          state <= ST_BS;
        end
        ST_BS: begin
          cb[idx3(ax, ix)] <= csp_pkg::sat32(64'(s_r[ix]) - q3);
          state            <= ST_D;
        end

        ST_D: if (div_done) begin
          cd[idx3(ax, ix)] <= div_res;
          if (ix == 2'd2) begin
            ix <= 2'd0;
            if (ax == 2'd2) begin
              state <= ST_IDLE;
            end else begin
              ax    <= ax + 2'd1;
              state <= ST_S;
            end
          end else begin
            ix    <= i_nx;
            state <= ST_BM;
          end
        end

        // first segment with t_i <= q < t_i+1
        ST_ESRCH: begin
          if (q_r >= kt[ix] && q_r < kt[i_nx]) begin
            seg   <= ix;
            state <= ST_EDT;
          end else if (ix == 2'd2) begin
            for (int j = 0; j < 3; j++) begin
              ox[j] <= 32'sd0;
            end
            seg   <= 2'd3;
            state <= ST_EOUT;
          end else begin
            ix <= i_nx;
          end
        end

        ST_EDT: begin
          dt    <= csp_pkg::sat32(64'(q_r) - 64'(kt[seg]));
          ax    <= 2'd0;
          k     <= 2'd0;
          v     <= cd[idx3(2'd0, seg)];
          state <= ST_EMUL;
        end

        // Horner steps: d -> c -> b -> p
        ST_EMUL: if (mul_done) begin
          if (k == 2'd2) begin
            ox[ax] <= csp_pkg::sat32(64'(addend) + 64'(mul_res));
            k      <= 2'd0;
            if (ax == 2'd2) begin
              state <= ST_EOUT;
            end else begin
              ax <= ax + 2'd1;
              v  <= cd[idx3(ax + 2'd1, seg)];
            end
          end else begin
            v <= csp_pkg::sat32(64'(addend) + 64'(mul_res));
            k <= k + 2'd1;
          end
        end

        ST_EOUT: begin
          if (!res_valid || !res_stall) begin
            res.out_x    <= ox[0];
            res.out_y    <= ox[1];
            res.out_z    <= ox[2];
            res.in_range <= (seg != 2'd3);
            res_valid    <= 1'b1;
            state        <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
